>>> hdl/bpfa_pkg.sv
// Shared field widths, command, status and register codes of the page frame allocator.
`default_nettype none

package bpfa_pkg;

    // Item fields
    localparam int FUNC_W     = 2;
    localparam int ADDR_IN_W  = 28;
    localparam int STATUS_W   = 2;
    localparam int FADDR_W    = 27;
    localparam int COUNT_W    = 16;

    // Bus words
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    // Configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TOTAL_W    = 16;
    localparam int KFIRST_W   = 15;
    localparam int KCOUNT_W   = 16;

    // Map storage word
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;

    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFREE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FIRST_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FRAME_COUNT = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 16'd32768;
    localparam logic [KFIRST_W-1:0] KFIRST_RESET = 15'd0;
    localparam logic [KCOUNT_W-1:0] KCOUNT_RESET = 16'd0;

endpackage

`default_nettype wire

>>> hdl/bpfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/bitmap_page_frame_allocator.sv
// Bitmap page frame allocator: command sequencer over a word-wide page map RAM.
//
// Keeps one bit per page frame (1 = used or reserved) in a RAM of 32-bit map words and a
// 16-bit count of pages in use. Commands arrive as one word on the s_ side: init rebuilds the
// map from the three configuration registers, alloc returns the lowest free frame's byte
// address, free clears the frame holding a byte address. Each command yields exactly one
// result word on the m_ side. The block handles one command at a time; s_tready is high only
// while it is idle. With W = ceil(MAP_FRAMES/32) map words (1024 by default): after reset the
// map is filled with ones, word by word, before the first command is taken. Init writes all
// W map words, one map word written per cycle. Alloc reads the map words in turn up to and
// including the one holding the lowest free frame, or up to the last word below the total
// when none is free (one RAM read and one check per word). Free does a read-modify-write of
// one word. Other commands go straight to the result. A finished result waits in the output
// register while the next command is taken.
`default_nettype none

module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAP_FRAMES         = 32768,
    parameter int PAGE_BYTES         = 4096,
    parameter int FIRST_USABLE_FRAME = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // command
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // func[1:0], page_address[29:2], zero
    // result
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // status[1:0], frame_address[28:2],
                                                  // used_count[44:29], zero
    // configuration
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WORDS    = (MAP_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FRAME_W  = WADDR_W + BIT_W;
    localparam int CMP_W    = (FRAME_W + 1 > 17) ? FRAME_W + 1 : 17;
    localparam int HI_W     = CMP_W - BIT_W;
    localparam int PG_SHIFT = $clog2(PAGE_BYTES);
    localparam int FA_W     = ADDR_IN_W - PG_SHIFT;
    localparam int FX_W     = (FA_W > CMP_W) ? FA_W : CMP_W;
    localparam int SH_W     = (FRAME_W + PG_SHIFT > FADDR_W) ? FRAME_W + PG_SHIFT : FADDR_W;

    localparam logic [CMP_W-1:0]   MAP_LIMIT = CMP_W'(MAP_FRAMES);
    localparam logic [CMP_W-1:0]   FIRST_LO  = CMP_W'(FIRST_USABLE_FRAME);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SWEEP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FREE_RD,
        ST_FREE_MOD,
        ST_DONE
    } state_t;

    // Bits of word w at or above frame lo
    function automatic logic [WORD_W-1:0] ge_mask(logic [WADDR_W-1:0] w, logic [CMP_W-1:0] lo);
        logic [HI_W-1:0] wx;
        logic [HI_W-1:0] lw;
        wx = HI_W'(w);
        lw = lo[CMP_W-1:BIT_W];
        if (wx > lw) begin
            ge_mask = {WORD_W{1'b1}};
        end else if (wx == lw) begin
            ge_mask = {WORD_W{1'b1}} << lo[BIT_W-1:0];
        end else begin
            ge_mask = '0;
        end
    endfunction

    // Bits of word w below frame hi
    function automatic logic [WORD_W-1:0] lt_mask(logic [WADDR_W-1:0] w, logic [CMP_W-1:0] hi);
        logic [HI_W-1:0] wx;
        logic [HI_W-1:0] hw;
        wx = HI_W'(w);
        hw = hi[CMP_W-1:BIT_W];
        if (wx < hw) begin
            lt_mask = {WORD_W{1'b1}};
        end else if (wx == hw) begin
            lt_mask = ~({WORD_W{1'b1}} << hi[BIT_W-1:0]);
        end else begin
            lt_mask = '0;
        end
    endfunction

    // Configuration registers
    logic [TOTAL_W-1:0]  total_frames_reg;
    logic [KFIRST_W-1:0] kernel_first_reg;
    logic [KCOUNT_W-1:0] kernel_count_reg;

    // Bounds derived from configuration
    logic [CMP_W-1:0] tot_reg;
    logic [CMP_W-1:0] klo_reg;
    logic [CMP_W-1:0] khi_reg;

    // Sequencer
    state_t                state_reg;
    logic [WADDR_W-1:0]    word_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [ADDR_IN_W-1:0]  addr_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [COUNT_W-1:0]    cnt_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [FADDR_W-1:0]    m_faddr_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    // Datapath
    logic [WORD_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_we;
    logic [WORD_W-1:0]     init_word;
    logic [WORD_W-1:0]     scan_avail;
    logic                  scan_hit;
    logic [BIT_W-1:0]      scan_bit;
    logic                  scan_last;
    logic [CMP_W-1:0]      tot_m1;
    logic [FX_W-1:0]       free_frame;
    logic                  free_in_range;
    logic [SH_W-1:0]       faddr_wide;
    logic                  accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, m_count_reg, m_faddr_reg, m_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_frames_reg <= TOTAL_RESET;
            kernel_first_reg <= KFIRST_RESET;
            kernel_count_reg <= KCOUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TOTAL_FRAMES:       total_frames_reg <= cfg_data;
                REG_KERNEL_FIRST_FRAME: kernel_first_reg <= cfg_data[KFIRST_W-1:0];
                REG_KERNEL_FRAME_COUNT: kernel_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Track config; every command passes through PREP first so these are current
    always_ff @(posedge aclk) begin
        if (CMP_W'(total_frames_reg) > MAP_LIMIT) begin
            tot_reg <= MAP_LIMIT;
        end else begin
            tot_reg <= CMP_W'(total_frames_reg);
        end
        klo_reg <= CMP_W'(kernel_first_reg);
        khi_reg <= CMP_W'(kernel_first_reg) + CMP_W'(kernel_count_reg);
    end

    always_comb begin
        init_word = ~(ge_mask(word_reg, FIRST_LO) & lt_mask(word_reg, tot_reg))
                    | (ge_mask(word_reg, klo_reg) & lt_mask(word_reg, khi_reg));

        scan_avail = ~ram_rdata & lt_mask(word_reg, tot_reg);
        scan_hit   = |scan_avail;
        scan_bit   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (scan_avail[i]) begin
                scan_bit = BIT_W'(i);
            end
        end
        tot_m1    = tot_reg - CMP_W'(1);
        scan_last = (HI_W'(word_reg) == tot_m1[CMP_W-1:BIT_W]);

        free_frame    = FX_W'(addr_reg[ADDR_IN_W-1:PG_SHIFT]);
        free_in_range = (free_frame < FX_W'(tot_reg));

        faddr_wide = SH_W'(frame_reg) << PG_SHIFT;

        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = {WORD_W{1'b1}};
            end
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_wdata = init_word;
            end
            ST_SCAN_CHK: begin
                ram_we    = scan_hit;
                ram_wdata = ram_rdata | (WORD_W'(1) << scan_bit);
            end
            ST_FREE_MOD: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WORD_W'(1) << frame_reg[BIT_W-1:0]);
            end
            default: ;
        endcase
    end

    bpfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .raddr (word_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            word_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // DONE reloads the output register itself
            if (m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    word_reg <= word_reg + WADDR_W'(1);
                    if (word_reg == LAST_WORD) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        func_reg  <= s_tdata[FUNC_W-1:0];
                        addr_reg  <= s_tdata[FUNC_W +: ADDR_IN_W];
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    status_reg <= STATUS_OK;
                    word_reg   <= '0;
                    unique case (func_reg)
                        FUNC_INIT: state_reg <= ST_SWEEP;
                        FUNC_ALLOC: begin
                            if (tot_reg == '0) begin
                                status_reg <= STATUS_NOFREE;
                                state_reg  <= ST_DONE;
                            end else begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                        FUNC_FREE: begin
                            if (free_in_range) begin
                                frame_reg <= free_frame[FRAME_W-1:0];
                                word_reg  <= free_frame[FRAME_W-1:BIT_W];
                                state_reg <= ST_FREE_RD;
                            end else begin
                                status_reg <= STATUS_IGNORED;
                                state_reg  <= ST_DONE;
                            end
                        end
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_SWEEP: begin
                    word_reg <= word_reg + WADDR_W'(1);
                    if (word_reg == LAST_WORD) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SCAN_RD: begin
                    state_reg <= ST_SCAN_CHK;
                end
                ST_SCAN_CHK: begin
                    if (scan_hit) begin
                        frame_reg <= {word_reg, scan_bit};
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_reg <= cnt_reg + COUNT_W'(1);
                        end
                        state_reg <= ST_DONE;
                    end else if (scan_last) begin
                        status_reg <= STATUS_NOFREE;
                        state_reg  <= ST_DONE;
                    end else begin
                        word_reg  <= word_reg + WADDR_W'(1);
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_FREE_RD: begin
                    state_reg <= ST_FREE_MOD;
                end
                ST_FREE_MOD: begin
                    if (cnt_reg != '0) begin
                        cnt_reg <= cnt_reg - COUNT_W'(1);
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_count_reg  <= cnt_reg;
                        if (func_reg == FUNC_ALLOC && status_reg == STATUS_OK) begin
                            m_faddr_reg <= faddr_wide[FADDR_W-1:0];
                        end else begin
                            m_faddr_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("command taken while a previous one is in progress");

    a_no_map_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("page map written while idle");

    a_count_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> $stable(cnt_reg))
        else $error("used count changed with no command in progress");

    a_nofree_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg == STATUS_NOFREE) |-> (m_faddr_reg == '0))
        else $error("nonzero frame address reported with no free page");

endmodule

`default_nettype wire
